/* rtl/spst_pkg.sv */
`default_nettype none
package spst_pkg;

    // job set size and derived widths
    localparam int MAX_JOBS = 16;
    localparam int ADDR_W   = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
    localparam int CNT_W    = $clog2(MAX_JOBS + 1);

    // fixed field widths
    localparam int ARR_W  = 16;
    localparam int BUR_W  = 16;
    localparam int PRI_W  = 8;
    localparam int NUM_W  = 5;
    localparam int TIME_W = 21;
    localparam int SUM_W  = 25;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
    localparam logic [SUM_W-1:0]  SUM_MAX  = {SUM_W{1'b1}};

    // one stored job
    typedef struct packed {
        logic [ARR_W-1:0] arrival;
        logic [BUR_W-1:0] burst;
        logic [PRI_W-1:0] prio;
        logic [NUM_W-1:0] number;
    } t_job;

    // timeline unit control
    typedef struct packed {
        logic start;
        logic clear;
    } t_tl_ctrl;

    // timeline unit results for one job
    typedef struct packed {
        logic [TIME_W-1:0] start_time;
        logic [TIME_W-1:0] completion_time;
        logic [TIME_W-1:0] waiting_time;
        logic [TIME_W-1:0] turnaround_time;
        logic [SUM_W-1:0]  waiting_sum;
        logic [SUM_W-1:0]  turnaround_sum;
    } t_tl_res;

endpackage
`default_nettype wire

/* rtl/spst_if.sv */
`default_nettype none
// input job channel
interface spst_job_if;
    logic        valid;
    logic        ready;
    logic [15:0] arrival_time;
    logic [15:0] burst_time;
    logic [7:0]  job_priority;
    logic        last_job;

    modport source (output valid, arrival_time, burst_time, job_priority, last_job,
                    input ready);
    modport sink   (input valid, arrival_time, burst_time, job_priority, last_job,
                    output ready);
endinterface

// result channel
interface spst_res_if;
    logic        valid;
    logic        ready;
    logic [4:0]  job_number;
    logic [20:0] start_time;
    logic [20:0] completion_time;
    logic [20:0] waiting_time;
    logic [20:0] turnaround_time;
    logic [24:0] waiting_sum;
    logic [24:0] turnaround_sum;
    logic [4:0]  job_count;
    logic        last_result;

    modport source (output valid, job_number, start_time, completion_time, waiting_time,
                    turnaround_time, waiting_sum, turnaround_sum, job_count,
                    last_result, input ready);
    modport sink   (input valid, job_number, start_time, completion_time, waiting_time,
                    turnaround_time, waiting_sum, turnaround_sum, job_count,
                    last_result, output ready);
endinterface
`default_nettype wire

/* rtl/static_priority_schedule_timeline_unit.sv */
`default_nettype none
// Non-preemptive priority scheduler. Jobs are loaded one per cycle on i_job
// and numbered from 1; the beat with last_job set is itself a job and closes
// the set (jobs beyond MAX_JOBS are dropped). The set is then ordered by
// priority, lower first, with a pairwise exchange sort over a job memory with
// one write port and one read port, one compare per cycle. The timeline walk
// then reads each job from memory, runs it through the four timeline unit
// steps and picks up its done flag, and waits on any output stall. One result
// beat per job leaves on o_res in schedule order, the final one flagged by
// last_result. i_job is not ready from the last job of a set until its final
// result is in the output register.
module static_priority_schedule_timeline_unit
    import spst_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    spst_job_if.sink  i_job,
    spst_res_if.source o_res
);

    localparam logic [2:0] S_LOAD = 3'd0;
    localparam logic [2:0] S_SA   = 3'd1;
    localparam logic [2:0] S_SC   = 3'd2;
    localparam logic [2:0] S_SB   = 3'd3;
    localparam logic [2:0] S_SW   = 3'd4;
    localparam logic [2:0] S_WR   = 3'd5;
    localparam logic [2:0] S_WS   = 3'd6;
    localparam logic [2:0] S_WE   = 3'd7;

    logic [2:0]        r_state, n_state;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [CNT_W-1:0]  r_n, n_n;
    logic [ADDR_W-1:0] r_a, n_a, r_b, n_b, r_k, n_k;
    t_job              r_cur, n_cur;

    // job memory
    t_job              r_mem [MAX_JOBS];
    t_job              r_rd;
    logic [ADDR_W-1:0] w_rd_addr;
    logic              w_we;
    logic [ADDR_W-1:0] w_wa;
    t_job              w_wd;

    // output register
    logic              r_out_valid, n_out_valid;
    t_tl_res           r_out_tl;
    logic [NUM_W-1:0]  r_out_num;
    logic [NUM_W-1:0]  r_out_cnt;
    logic              r_out_last;
    logic              w_out_load;

    t_tl_ctrl          w_tl_ctrl;
    logic              w_tl_done;
    t_tl_res           w_tl_res;

    logic              w_accept;
    logic [CNT_W-1:0]  w_last_idx;

    assign w_accept   = i_job.valid && i_job.ready;
    assign w_last_idx = r_n - 1'b1;

    spst_timeline u_timeline (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (w_tl_ctrl),
        .i_arrival (r_rd.arrival),
        .i_burst   (r_rd.burst),
        .o_done    (w_tl_done),
        .o_res     (w_tl_res)
    );

    // sequencer: load, exchange sort, timeline walk
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_n         = r_n;
        n_a         = r_a;
        n_b         = r_b;
        n_k         = r_k;
        n_cur       = r_cur;
        n_out_valid = r_out_valid;
        w_rd_addr   = r_k;
        w_we        = 1'b0;
        w_wa        = r_b;
        w_wd        = r_cur;
        w_out_load  = 1'b0;
        w_tl_ctrl   = '0;

        if (r_out_valid && o_res.ready) n_out_valid = 1'b0;

        unique case (r_state)
            S_LOAD: begin
                if (w_accept) begin
                    if (r_cnt < CNT_W'(MAX_JOBS)) begin
                        w_we           = 1'b1;
                        w_wa           = r_cnt[ADDR_W-1:0];
                        w_wd.arrival   = i_job.arrival_time;
                        w_wd.burst     = i_job.burst_time;
                        w_wd.prio      = i_job.job_priority;
                        w_wd.number    = NUM_W'(r_cnt + 1'b1);
                        n_cnt          = r_cnt + 1'b1;
                    end
                    if (i_job.last_job) begin
                        n_n = n_cnt;
                        n_a = '0;
                        n_k = '0;
                        n_state = (n_cnt > CNT_W'(1)) ? S_SA : S_WR;
                    end
                end
            end
            S_SA: begin
                w_rd_addr = r_a;
                n_b       = r_a + 1'b1;
                n_state   = S_SC;
            end
            S_SC: begin
                n_cur     = r_rd;
                w_rd_addr = r_b;
                n_state   = S_SB;
            end
            S_SB: begin
                // keep the running candidate for slot a; park the loser at b
                if (r_cur.prio > r_rd.prio) begin
                    w_we  = 1'b1;
                    w_wa  = r_b;
                    w_wd  = r_cur;
                    n_cur = r_rd;
                end
                if (CNT_W'(r_b) == w_last_idx) begin
                    n_state = S_SW;
                end else begin
                    n_b       = r_b + 1'b1;
                    w_rd_addr = r_b + 1'b1;
                end
            end
            S_SW: begin
                w_we = 1'b1;
                w_wa = r_a;
                w_wd = r_cur;
                if (CNT_W'(r_a) + 1'b1 == w_last_idx) begin
                    n_k     = '0;
                    n_state = S_WR;
                end else begin
                    n_a     = r_a + 1'b1;
                    n_state = S_SA;
                end
            end
            S_WR: begin
                n_state = S_WS;
            end
            S_WS: begin
                n_cur           = r_rd;
                w_tl_ctrl.start = 1'b1;
                n_state         = S_WE;
            end
            S_WE: begin
                if (w_tl_done && (!r_out_valid || o_res.ready)) begin
                    w_out_load  = 1'b1;
                    n_out_valid = 1'b1;
                    if (CNT_W'(r_k) == w_last_idx) begin
                        w_tl_ctrl.clear = 1'b1;
                        n_cnt           = '0;
                        n_state         = S_LOAD;
                    end else begin
                        n_k     = r_k + 1'b1;
                        n_state = S_WR;
                    end
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_cnt       <= '0;
            r_n         <= '0;
            r_a         <= '0;
            r_b         <= '0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_n         <= n_n;
            r_a         <= n_a;
            r_b         <= n_b;
            r_k         <= n_k;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_cur <= n_cur;
        if (w_out_load) begin
            r_out_tl   <= w_tl_res;
            r_out_num  <= r_cur.number;
            r_out_cnt  <= NUM_W'(r_n);
            r_out_last <= (CNT_W'(r_k) == w_last_idx);
        end
    end

    // job memory: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_wa] <= w_wd;
        r_rd <= r_mem[w_rd_addr];
    end

    assign i_job.ready           = (r_state == S_LOAD);
    assign o_res.valid           = r_out_valid;
    assign o_res.job_number      = r_out_num;
    assign o_res.start_time      = r_out_tl.start_time;
    assign o_res.completion_time = r_out_tl.completion_time;
    assign o_res.waiting_time    = r_out_tl.waiting_time;
    assign o_res.turnaround_time = r_out_tl.turnaround_time;
    assign o_res.waiting_sum     = r_out_tl.waiting_sum;
    assign o_res.turnaround_sum  = r_out_tl.turnaround_sum;
    assign o_res.job_count       = r_out_cnt;
    assign o_res.last_result     = r_out_last;

endmodule
`default_nettype wire

/* rtl/spst_timeline.sv */
`default_nettype none
// Timeline step unit: one job's times and running totals over four steps.
module spst_timeline
    import spst_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_tl_ctrl            i_ctrl,
    input  wire logic [ARR_W-1:0]    i_arrival,
    input  wire logic [BUR_W-1:0]    i_burst,
    output logic                     o_done,
    output t_tl_res                  o_res
);

    localparam logic [2:0] T_IDLE = 3'd0;
    localparam logic [2:0] T_MAX  = 3'd1;
    localparam logic [2:0] T_ADD  = 3'd2;
    localparam logic [2:0] T_SUB  = 3'd3;
    localparam logic [2:0] T_SUM  = 3'd4;

    logic [2:0]        r_state, n_state;
    logic              r_done;
    logic [TIME_W-1:0] r_now;
    logic [SUM_W-1:0]  r_wsum, r_tsum;
    logic [TIME_W-1:0] r_arr;
    logic [BUR_W-1:0]  r_bur;
    logic [TIME_W-1:0] r_start, r_cmpl, r_wait, r_turn;

    logic [TIME_W:0]   w_cmpl_sum;
    logic [SUM_W:0]    w_wsum_sum, w_tsum_sum;

    assign w_cmpl_sum = {1'b0, r_start} + {{(TIME_W + 1 - BUR_W){1'b0}}, r_bur};
    assign w_wsum_sum = {1'b0, r_wsum} + {{(SUM_W + 1 - TIME_W){1'b0}}, r_wait};
    assign w_tsum_sum = {1'b0, r_tsum} + {{(SUM_W + 1 - TIME_W){1'b0}}, r_turn};

    // step sequence
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            T_IDLE:  if (i_ctrl.start) n_state = T_MAX;
            T_MAX:   n_state = T_ADD;
            T_ADD:   n_state = T_SUB;
            T_SUB:   n_state = T_SUM;
            T_SUM:   n_state = T_IDLE;
            default: n_state = T_IDLE;
        endcase
    end

    // control state: sequencer, timeline and totals
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= T_IDLE;
            r_done  <= 1'b0;
            r_now   <= '0;
            r_wsum  <= '0;
            r_tsum  <= '0;
        end else if (i_ctrl.clear) begin
            r_state <= T_IDLE;
            r_done  <= 1'b0;
            r_now   <= '0;
            r_wsum  <= '0;
            r_tsum  <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == T_IDLE && i_ctrl.start) r_done <= 1'b0;
            if (r_state == T_SUB) begin
                r_wsum <= w_wsum_sum[SUM_W] ? SUM_MAX : w_wsum_sum[SUM_W-1:0];
            end
            if (r_state == T_SUM) begin
                r_tsum <= w_tsum_sum[SUM_W] ? SUM_MAX : w_tsum_sum[SUM_W-1:0];
                r_now  <= r_cmpl;
                r_done <= 1'b1;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            T_IDLE: begin
                if (i_ctrl.start) begin
                    r_arr <= {{(TIME_W - ARR_W){1'b0}}, i_arrival};
                    r_bur <= i_burst;
                end
            end
            T_MAX: begin
                r_start <= (r_now < r_arr) ? r_arr : r_now;
            end
            T_ADD: begin
                r_cmpl <= w_cmpl_sum[TIME_W] ? TIME_MAX : w_cmpl_sum[TIME_W-1:0];
                r_wait <= r_start - r_arr;
            end
            T_SUB: begin
                r_turn <= r_cmpl - r_arr;
            end
            default: begin
            end
        endcase
    end

    assign o_done                = r_done;
    assign o_res.start_time      = r_start;
    assign o_res.completion_time = r_cmpl;
    assign o_res.waiting_time    = r_wait;
    assign o_res.turnaround_time = r_turn;
    assign o_res.waiting_sum     = r_wsum;
    assign o_res.turnaround_sum  = r_tsum;

endmodule
`default_nettype wire
